// ===== hdl/pspa_pkg.sv =====
`timescale 1ns / 1ps

package pspa_pkg;

  // Field widths fixed by the transaction format
  localparam int PEER_W  = 8;
  localparam int STAMP_W = 32;
  localparam int MASK_W  = 8;
  localparam int SLOT_W  = 3;
  localparam int ENTRY_W = PEER_W + STAMP_W;

  typedef logic [PEER_W-1:0]  peer_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [MASK_W-1:0]  mask_t;
  typedef logic [SLOT_W-1:0]  slot_t;

  // How the slot was chosen
  typedef enum logic [1:0] {
    OUT_HIT  = 2'd0,
    OUT_FREE = 2'd1,
    OUT_IDLE = 2'd2,
    OUT_LIVE = 2'd3
  } outcome_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Age compare verdict for one used slot
  typedef struct packed {
    logic take_any;
    logic take_idle;
  } age_cmp_t;

endpackage

// ===== hdl/pspa_if.sv =====
`timescale 1ns / 1ps

// Request channel: peer, time and live mask
interface pspa_req_if;
  import pspa_pkg::*;

  logic   valid;
  logic   ready;
  peer_t  peer_addr;
  stamp_t now_ms;
  mask_t  live_mask;

  modport source (output valid, output peer_addr, output now_ms, output live_mask,
                  input ready);
  modport sink   (input valid, input peer_addr, input now_ms, input live_mask,
                  output ready);
endinterface

// Response channel: chosen slot and outcome
interface pspa_rsp_if;
  import pspa_pkg::*;

  logic     valid;
  logic     ready;
  slot_t    slot_index;
  outcome_t outcome;

  modport source (output valid, output slot_index, output outcome, input ready);
  modport sink   (input valid, input slot_index, input outcome, output ready);
endinterface

// ===== hdl/pspa_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read
module pspa_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/pspa_age_unit.sv =====
`timescale 1ns / 1ps

// Shared age unit: one wrapping subtract, compared against both running maxima
module pspa_age_unit (
  input  pspa_pkg::stamp_t   now_ms,
  input  pspa_pkg::stamp_t   stamp,
  input  logic               live,
  input  logic               have_any,
  input  pspa_pkg::stamp_t   any_age,
  input  logic               have_idle,
  input  pspa_pkg::stamp_t   idle_age,
  output pspa_pkg::stamp_t   age,
  output pspa_pkg::age_cmp_t cmp
);
  import pspa_pkg::*;

  // Modulo 2^32 age; strict greater keeps the earlier index on ties
  assign age = now_ms - stamp;

  always_comb begin
    cmp.take_any  = !have_any || (age > any_age);
    cmp.take_idle = !live && (!have_idle || (age > idle_age));
  end

endmodule

// ===== hdl/per_peer_slot_allocator_lru.sv =====
`timescale 1ns / 1ps

// Per-peer slot allocator with least-recently-used replacement.
// req (sink) carries peer_addr, now_ms and live_mask; rsp (source) returns
// slot_index and outcome (own hit, free slot, idle LRU reused, live LRU
// displaced). One response per request transaction.
// Peer and timestamp per slot live in one RAM; a sequencer reads one slot
// per cycle and feeds a single age subtract/compare unit. A matching peer
// ends the scan early. The scan reads the slots in turn through the one RAM
// read port; req.ready rises again in the cycle the response is shown, so
// a new request is taken only once the previous one has its response.
// The response sits in an output register; the next request may be
// accepted while it waits. If rsp is still stalled when the following
// result is ready, the sequencer holds in its final state until it drains.
// Reset clears the used bits and control; RAM contents need no clearing
// since only used slots are ever compared.
module per_peer_slot_allocator_lru #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  pspa_req_if.sink    req,
  pspa_rsp_if.source  rsp
);
  import pspa_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  state_t state, state_next;

  // Latched request
  peer_t  peer_q;
  stamp_t now_q;
  mask_t  mask_q;

  // Scan pointer and read pipeline
  logic [CNT_W-1:0] scan_cnt;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_en;

  // Slot state
  logic [NUM_SLOTS-1:0] used;
  logic [NUM_SLOTS-1:0] live_vec;

  // Running selections
  logic             have_free, have_free_next;
  logic [IDX_W-1:0] free_idx, free_idx_next;
  logic             have_any, have_any_next;
  logic [IDX_W-1:0] any_idx, any_idx_next;
  stamp_t           any_age, any_age_next;
  logic             have_idle, have_idle_next;
  logic [IDX_W-1:0] idle_idx, idle_idx_next;
  stamp_t           idle_age, idle_age_next;

  // Decision
  logic             hit, last, done;
  logic [IDX_W-1:0] sel_idx, sel_idx_next;
  outcome_t         sel_out, sel_out_next;

  logic               ram_we;
  logic               fin_load;
  logic [ENTRY_W-1:0] rdata;
  peer_t              rd_peer;
  stamp_t             rd_stamp;
  stamp_t             age;
  age_cmp_t           cmp;

  assign rd_peer  = rdata[ENTRY_W-1:STAMP_W];
  assign rd_stamp = rdata[STAMP_W-1:0];

  // Slot memory: peer and last-touch stamp
  pspa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(sel_idx),
    .wdata({peer_q, now_q}),
    .re   (rd_en),
    .raddr(scan_cnt[IDX_W-1:0]),
    .rdata(rdata)
  );

  // Only the first eight slots have a live bit
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      live_vec[i] = (i < MASK_W) ? mask_q[3'(i)] : 1'b0;
    end
  end

  pspa_age_unit u_age (
    .now_ms   (now_q),
    .stamp    (rd_stamp),
    .live     (live_vec[rd_idx]),
    .have_any (have_any),
    .any_age  (any_age),
    .have_idle(have_idle),
    .idle_age (idle_age),
    .age      (age),
    .cmp      (cmp)
  );

  // Per-slot evaluation and final choice
  always_comb begin
    have_free_next = have_free;
    free_idx_next  = free_idx;
    have_any_next  = have_any;
    any_idx_next   = any_idx;
    any_age_next   = any_age;
    have_idle_next = have_idle;
    idle_idx_next  = idle_idx;
    idle_age_next  = idle_age;
    hit            = 1'b0;
    if (rd_vld) begin
      if (used[rd_idx] && (rd_peer == peer_q)) begin
        hit = 1'b1;
      end else if (!used[rd_idx]) begin
        if (!have_free) begin
          have_free_next = 1'b1;
          free_idx_next  = rd_idx;
        end
      end else begin
        if (cmp.take_any) begin
          have_any_next = 1'b1;
          any_idx_next  = rd_idx;
          any_age_next  = age;
        end
        if (cmp.take_idle) begin
          have_idle_next = 1'b1;
          idle_idx_next  = rd_idx;
          idle_age_next  = age;
        end
      end
    end
    last = rd_vld && (rd_idx == IDX_W'(NUM_SLOTS - 1));
    done = (state == ST_SCAN) && (hit || last);
    if (hit) begin
      sel_idx_next = rd_idx;
      sel_out_next = OUT_HIT;
    end else if (have_free_next) begin
      sel_idx_next = free_idx_next;
      sel_out_next = OUT_FREE;
    end else if (have_idle_next) begin
      sel_idx_next = idle_idx_next;
      sel_out_next = OUT_IDLE;
    end else begin
      sel_idx_next = any_idx_next;
      sel_out_next = OUT_LIVE;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!rsp.valid || rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req.ready = 1'b0;
    rd_en     = 1'b0;
    ram_we    = 1'b0;
    fin_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
      end
      ST_SCAN: begin
        rd_en = (scan_cnt < CNT_W'(NUM_SLOTS));
      end
      ST_FINISH: begin
        ram_we   = 1'b1;
        fin_load = !rsp.valid || rsp.ready;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_vld    <= 1'b0;
      used      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (ram_we) used[sel_idx] <= 1'b1;
      if (fin_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_idx <= scan_cnt[IDX_W-1:0];
    if (req.valid && req.ready) begin
      peer_q    <= req.peer_addr;
      now_q     <= req.now_ms;
      mask_q    <= req.live_mask;
      scan_cnt  <= '0;
      have_free <= 1'b0;
      have_any  <= 1'b0;
      have_idle <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (rd_en) scan_cnt <= scan_cnt + CNT_W'(1);
      have_free <= have_free_next;
      free_idx  <= free_idx_next;
      have_any  <= have_any_next;
      any_idx   <= any_idx_next;
      any_age   <= any_age_next;
      have_idle <= have_idle_next;
      idle_idx  <= idle_idx_next;
      idle_age  <= idle_age_next;
    end
    if (done) begin
      sel_idx <= sel_idx_next;
      sel_out <= sel_out_next;
    end
    if (fin_load) begin
      rsp.slot_index <= SLOT_W'(sel_idx);
      rsp.outcome    <= sel_out;
    end
  end

endmodule

// ===== hdl/pspa_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks for the slot allocator
module pspa_checker #(
  parameter int NUM_SLOTS = 8
) (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input logic [2:0] rsp_slot_index,
  input logic [1:0] rsp_outcome
);

  // One request at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one in progress");

  // Stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_index)
                                && $stable(rsp_outcome))
    else $error("stalled response changed");

  // No stale response after reset
  a_rsp_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  // Chosen slot lies within the table
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (NUM_SLOTS <= 8) |-> (int'(rsp_slot_index) < NUM_SLOTS))
    else $error("slot index beyond table");

endmodule

bind per_peer_slot_allocator_lru pspa_checker #(
  .NUM_SLOTS(NUM_SLOTS)
) u_pspa_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_slot_index(rsp.slot_index),
  .rsp_outcome   (rsp.outcome)
);
